// ===== rtl/cdma_pkg.sv =====
// Package for the cartridge DMA register controller: types, codes and reset constants.
// Used by the top level, cdma_front and cdma_back; no dependencies.
`timescale 1ns / 1ps
package cdma_pkg;
	localparam int DramAddrBitsDefault = 24;
	localparam logic [24:0] DramSizeReset = 25'h0400000;
	localparam logic [31:0] CartBaseReset = 32'h10000000;
	localparam logic [31:0] CartEndReset = 32'h1fc00000;
	localparam logic [31:0] CartAddrMask = 32'h3fffffff;

	typedef enum logic [1:0] {
		FUNC_READ = 2'd0,
		FUNC_WRITE = 2'd1,
		FUNC_TICK = 2'd2,
		FUNC_NONE = 2'd3
	} func_t;

	typedef enum logic [2:0] {
		ERR_OK = 3'd0,
		ERR_BUSY = 3'd1,
		ERR_ALIGN = 3'd2,
		ERR_DEST = 3'd3,
		ERR_SRC = 3'd4,
		ERR_UNKNOWN = 3'd5,
		ERR_RESET = 3'd6,
		ERR_SPARE = 3'd7
	} err_t;

	typedef enum logic [1:0] {
		CFG_DRAM_SIZE = 2'd0,
		CFG_CART_BASE = 2'd1,
		CFG_CART_END = 2'd2,
		CFG_NONE = 2'd3
	} cfg_idx_t;

	// Kind of operation decided by the front part.
	typedef enum logic [2:0] {
		OP_NOP,
		OP_TICK,
		OP_READ,
		OP_WRITE,
		OP_BADREG
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [3:0]  reg_idx;
		logic [31:0] data;
	} cmd_t;

	typedef struct packed {
		logic        handled;
		logic [31:0] read_data;
		logic [2:0]  error_code;
		logic        intr_raise;
		logic        intr_clear;
		logic        dma_busy;
		logic        copy_valid;
		logic        copy_to_cart;
		logic [23:0] copy_dram_addr;
		logic [31:0] copy_cart_addr;
		logic [31:0] copy_length;
	} res_t;
endpackage

// ===== rtl/cart_dma_register_controller.sv =====
// Top level of the cartridge DMA register controller.
// Depends on cdma_pkg, cdma_front and cdma_back.
`timescale 1ns / 1ps
// One input transaction is a register read, a register write or one clock tick, and
// each gives exactly one result transaction. The block takes one transaction per
// cycle while the queue has room: the front part decodes it into a two-entry command
// queue, and the back part, which holds the DMA registers and transfer countdown,
// completes one command per cycle into an output register unless the output stalls,
// which backs up the queue. A length write that passes its checks starts a transfer
// that finishes length+1 ticks later with an interrupt raise and a copy order.
// Configuration registers (DRAM size, cartridge window base and end) are written
// through cfg_we, cfg_index and cfg_data by the user only while idle (not enforced).
module cart_dma_register_controller #(
	parameter int DRAM_ADDR_BITS = cdma_pkg::DramAddrBitsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// func[1:0], access_bytes[5:2], address_offset[25:6], write_data[57:26]
	input  logic [63:0]  s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// handled[0], read_data[32:1], error_code[35:33], intr_raise[36], intr_clear[37],
	// dma_busy[38], copy_valid[39], copy_to_cart[40], copy_dram_addr[64:41],
	// copy_cart_addr[96:65], copy_length[128:97]
	output logic [135:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [1:0]   cfg_index,
	input  logic [31:0]  cfg_data
);
	logic [24:0] dram_size_q;
	logic [31:0] cart_base_q, cart_end_q;
	logic cmd_valid, cmd_ready;
	cdma_pkg::cmd_t cmd;
	cdma_pkg::res_t res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dram_size_q <= cdma_pkg::DramSizeReset;
			cart_base_q <= cdma_pkg::CartBaseReset;
			cart_end_q <= cdma_pkg::CartEndReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cdma_pkg::CFG_DRAM_SIZE: dram_size_q <= cfg_data[24:0];
				cdma_pkg::CFG_CART_BASE: cart_base_q <= cfg_data;
				cdma_pkg::CFG_CART_END: cart_end_q <= cfg_data;
				default: ;
			endcase
		end
	end

	cdma_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.func(s_axis_tdata[1:0]), .access_bytes(s_axis_tdata[5:2]),
		.address_offset(s_axis_tdata[25:6]), .write_data(s_axis_tdata[57:26]),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd)
	);

	cdma_back #(.DRAM_ADDR_BITS(DRAM_ADDR_BITS)) u_back (
		.clk(clk), .arst_n(arst_n),
		.cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .cmd(cmd),
		.dram_size(dram_size_q), .cart_base(cart_base_q), .cart_end(cart_end_q),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {7'd0, res.copy_length, res.copy_cart_addr, res.copy_dram_addr,
		res.copy_to_cart, res.copy_valid, res.dma_busy, res.intr_clear, res.intr_raise,
		res.error_code, res.read_data, res.handled};
endmodule

// ===== rtl/cdma_front.sv =====
// Front part: accepts input transactions, decodes them and feeds a two-entry command queue.
// Depends on cdma_pkg.
`timescale 1ns / 1ps
module cdma_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [1:0]    func,
	input  logic [3:0]    access_bytes,
	input  logic [19:0]   address_offset,
	input  logic [31:0]   write_data,
	output logic          cmd_valid,
	input  logic          cmd_ready,
	output cdma_pkg::cmd_t cmd
);
	cdma_pkg::cmd_t dec;
	cdma_pkg::cmd_t fifo_q [2];
	logic           rd_ptr_q, wr_ptr_q;
	logic [1:0]     count_q;
	logic           push, pop;

	always_comb begin
		dec.reg_idx = address_offset[5:2];
		dec.data = write_data;
		unique case (func)
			cdma_pkg::FUNC_TICK: dec.op = cdma_pkg::OP_TICK;
			cdma_pkg::FUNC_READ, cdma_pkg::FUNC_WRITE: begin
				if (access_bytes != 4'd4) dec.op = cdma_pkg::OP_NOP;
				else if (address_offset[1:0] != 2'b00 || address_offset > 20'h30)
					dec.op = cdma_pkg::OP_BADREG;
				else if (func == cdma_pkg::FUNC_READ) dec.op = cdma_pkg::OP_READ;
				else dec.op = cdma_pkg::OP_WRITE;
			end
			default: dec.op = cdma_pkg::OP_NOP;
		endcase
	end

	assign in_ready = count_q != 2'd2;
	assign push = in_valid && in_ready;
	assign cmd_valid = count_q != 2'd0;
	assign pop = cmd_valid && cmd_ready;
	assign cmd = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= dec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= 1'b0;
			wr_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

// ===== rtl/cdma_back.sv =====
// Back part: register file, transfer checks, countdown and result register.
// Depends on cdma_pkg.
`timescale 1ns / 1ps
module cdma_back #(
	parameter int DRAM_ADDR_BITS = cdma_pkg::DramAddrBitsDefault
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  cdma_pkg::cmd_t cmd,
	input  logic [24:0]    dram_size,
	input  logic [31:0]    cart_base,
	input  logic [31:0]    cart_end,
	output logic           res_valid,
	input  logic           res_ready,
	output cdma_pkg::res_t res
);
	localparam int MaskBits = (DRAM_ADDR_BITS < 24) ? DRAM_ADDR_BITS : 24;
	localparam logic [23:0] DramMask = 24'((33'd1 << MaskBits) - 33'd1);

	logic [23:0] dram_addr_q, lat_dram_q;
	logic [31:0] cart_addr_q, rd_len_q, wr_len_q, lat_cart_q, ticks_q;
	logic [31:0] timing_q [8];
	logic        busy_q, pend_q, pend_cart_q;
	cdma_pkg::res_t res_q, r;
	logic        res_valid_q, go;

	logic [31:0] len, cart_msk, cdst, csrc;
	logic [32:0] sum_rc, sum_rd, sum_wd, sum_wc;
	logic        start, start_cart;
	logic [31:0] t1;
	logic [32:0] wl1, fits;

	assign go = cmd_valid && (!res_valid_q || res_ready);
	assign cmd_ready = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign res = res_q;

	always_comb begin
		len = cmd.data + 32'd1;
		cart_msk = cart_addr_q & cdma_pkg::CartAddrMask;
		cdst = cart_msk;
		csrc = cart_addr_q;
		sum_rc = {1'b0, cdst} + {1'b0, len};
		sum_rd = {9'd0, dram_addr_q} + {1'b0, len};
		sum_wd = {9'd0, dram_addr_q} + {1'b0, len};
		sum_wc = {1'b0, csrc} + {1'b0, len};
		t1 = ticks_q - 32'd1;
		wl1 = {1'b0, wr_len_q} + 33'd1;
		fits = {9'd0, lat_dram_q} + {1'b0, wl1[31:0]};
		start = 1'b0;
		start_cart = 1'b0;
		r = '0;
		r.dma_busy = busy_q;
		unique case (cmd.op)
			cdma_pkg::OP_TICK: begin
				r.handled = 1'b1;
				if (pend_q && t1 == 32'd0) begin
					r.intr_raise = 1'b1;
					r.copy_valid = 1'b1;
					r.dma_busy = 1'b0;
					r.copy_to_cart = pend_cart_q;
					r.copy_dram_addr = lat_dram_q;
					r.copy_cart_addr = lat_cart_q;
					if (pend_cart_q) r.copy_length = rd_len_q + 32'd1;
					else if ({8'd0, lat_dram_q} >= dram_size) r.copy_length = '0;
					else if (fits > {8'd0, dram_size})
						r.copy_length = 32'(dram_size - {1'b0, lat_dram_q});
					else r.copy_length = wl1[31:0];
				end
			end
			cdma_pkg::OP_BADREG: begin
				r.handled = 1'b1;
				r.error_code = cdma_pkg::ERR_UNKNOWN;
			end
			cdma_pkg::OP_READ: begin
				r.handled = 1'b1;
				case (cmd.reg_idx)
					4'd0: r.read_data = {8'd0, dram_addr_q};
					4'd1: r.read_data = cart_addr_q;
					4'd2: r.read_data = rd_len_q;
					4'd3: r.read_data = wr_len_q;
					4'd4: r.read_data = {31'd0, busy_q};
					default: r.read_data = timing_q[3'(cmd.reg_idx - 4'd5)];
				endcase
			end
			cdma_pkg::OP_WRITE: begin
				r.handled = 1'b1;
				case (cmd.reg_idx)
					4'd2: begin
						if (busy_q) r.error_code = cdma_pkg::ERR_BUSY;
						else if (dram_addr_q[2:0] != 3'd0 || cdst[0])
							r.error_code = cdma_pkg::ERR_ALIGN;
						else if (sum_rc[31:0] <= cdst || cdst < cart_base
							|| sum_rc > {1'b0, cart_end})
							r.error_code = cdma_pkg::ERR_DEST;
						else if (sum_rd[31:0] <= {8'd0, dram_addr_q}
							|| sum_rd > {8'd0, dram_size})
							r.error_code = cdma_pkg::ERR_SRC;
						else begin
							start = 1'b1;
							start_cart = 1'b1;
							r.dma_busy = 1'b1;
						end
					end
					4'd3: begin
						if (busy_q) r.error_code = cdma_pkg::ERR_BUSY;
						else if (csrc[0] || dram_addr_q[2:0] != 3'd0)
							r.error_code = cdma_pkg::ERR_ALIGN;
						else if (sum_wd[31:0] <= {8'd0, dram_addr_q}
							|| {8'd0, dram_addr_q} >= dram_size)
							r.error_code = cdma_pkg::ERR_DEST;
						else if (sum_wc[31:0] <= csrc || csrc < cart_base
							|| sum_wc > {1'b0, cart_end})
							r.error_code = cdma_pkg::ERR_SRC;
						else begin
							start = 1'b1;
							r.dma_busy = 1'b1;
						end
					end
					4'd4: begin
						r.dma_busy = 1'b0;
						if (cmd.data[0]) r.error_code = cdma_pkg::ERR_RESET;
						r.intr_clear = cmd.data[1];
					end
					default: ;
				endcase
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (go) res_q <= r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
			dram_addr_q <= '0; cart_addr_q <= '0; rd_len_q <= '0; wr_len_q <= '0;
			lat_dram_q <= '0; lat_cart_q <= '0; ticks_q <= '0;
			busy_q <= 1'b0; pend_q <= 1'b0; pend_cart_q <= 1'b0;
			for (int i = 0; i < 8; i++) timing_q[i] <= '0;
		end else begin
			if (cmd_ready) res_valid_q <= cmd_valid;
			if (go) begin
				busy_q <= r.dma_busy;
				if (cmd.op == cdma_pkg::OP_TICK && pend_q) begin
					ticks_q <= t1;
					if (t1 == 32'd0) pend_q <= 1'b0;
				end
				if (start) begin
					lat_dram_q <= dram_addr_q & DramMask;
					lat_cart_q <= start_cart ? cdst : csrc;
					pend_q <= 1'b1;
					pend_cart_q <= start_cart;
					ticks_q <= len;
					if (start_cart) rd_len_q <= cmd.data;
					else wr_len_q <= cmd.data;
				end
				if (cmd.op == cdma_pkg::OP_WRITE) begin
					case (cmd.reg_idx)
						4'd0: dram_addr_q <= cmd.data[23:0] & DramMask;
						4'd1: cart_addr_q <= cmd.data;
						4'd2, 4'd3, 4'd4: ;
						default: timing_q[3'(cmd.reg_idx - 4'd5)] <= cmd.data;
					endcase
				end
			end
		end
	end
endmodule

// ===== rtl/cdma_checker.sv =====
// Port-level checker for the cartridge DMA register controller, bound to the top level.
// Depends on cart_dma_register_controller ports only.
`timescale 1ns / 1ps
module cdma_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [135:0] m_axis_tdata
);
	a_copy_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tdata[39] |-> m_axis_tdata[128:41] == '0 && !m_axis_tdata[36])
		else $error("copy fields set without copy order");
	a_copy_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[39] |-> !m_axis_tdata[38])
		else $error("busy after completion");
	a_read_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[32:1] != '0 |-> m_axis_tdata[35:33] == 3'd0)
		else $error("read data with error");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");
endmodule

bind cart_dma_register_controller cdma_checker u_cdma_checker (
	.clk(clk), .arst_n(arst_n), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
